// ===== hw/rtl/glyph_bitmap_decompressor_macros.svh =====
// assertion helpers used by the checker file gbd_checker
`ifndef GLYPH_BITMAP_DECOMPRESSOR_MACROS_SVH
`define GLYPH_BITMAP_DECOMPRESSOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define GBD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define GBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gbd_pkg.sv =====
package gbd_pkg;

    // glyph size limits
    localparam int MAX_WIDTH   = 32;
    localparam int MAX_HEIGHT  = 255;
    localparam int ROW_CAP     = 32;
    localparam int ROW_IDX_W   = $clog2(ROW_CAP);
    localparam int WIDTH_CAP   = (MAX_WIDTH < ROW_CAP) ? MAX_WIDTH : ROW_CAP;
    localparam int HEIGHT_CAP  = (MAX_HEIGHT < 255) ? MAX_HEIGHT : 255;
    localparam int WORD_CAP    = 32;
    localparam int COUNT_W     = 6;
    localparam int PIXEL_CNT_W = 13;

    // command queue between parser and pixel engine
    localparam int QUEUE_DEPTH = 4;

    // input item kinds
    localparam logic ITEM_START = 1'b0;
    localparam logic ITEM_BIT   = 1'b1;

    // two-bit commands of the compressed stream, msb first
    localparam logic [1:0] CODE_ESCAPE    = 2'b00;
    localparam logic [1:0] CODE_WORD_LIT  = 2'b01;
    localparam logic [1:0] CODE_ROW_LIT   = 2'b10;
    localparam logic [1:0] CODE_ZERO_WORD = 2'b11;

    // configuration register indexes
    localparam logic [1:0] CFG_CLIP_LEFT   = 2'd0;
    localparam logic [1:0] CFG_CLIP_RIGHT  = 2'd1;
    localparam logic [1:0] CFG_CLIP_TOP    = 2'd2;
    localparam logic [1:0] CFG_CLIP_BOTTOM = 2'd3;

    typedef struct packed {
        logic               command;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [5:0]         glyph_width;
        logic [7:0]         glyph_height;
        logic [5:0]         word_length;
        logic [7:0]         ink_color;
        logic               stream_bit;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic               write_pixel;
        logic [7:0]         pixel_color;
        logic               glyph_done;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic signed [15:0] top;
        logic signed [15:0] bottom;
    } clip_t;

    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [5:0]         width;
        logic [5:0]         word_length;
        logic [7:0]         color;
    } glyph_cfg_t;

    typedef enum logic [1:0] {
        OP_ZERO = 2'd0,
        OP_LIT  = 2'd1,
        OP_ROW  = 2'd2,
        OP_WORD = 2'd3
    } op_t;

    // one decoded command for the pixel engine
    typedef struct packed {
        op_t                op;
        logic [COUNT_W-1:0] count;
        logic               pix_bit;
        logic               last;
    } cmd_t;

endpackage

// ===== hw/rtl/gbd_queue.sv =====
module gbd_queue
    import gbd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic full,
    output logic empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/gbd_front.sv =====
module gbd_front
    import gbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    input  logic       q_full,
    input  logic       back_quiet,
    output logic       push,
    output cmd_t       push_cmd,
    output logic       start,
    output glyph_cfg_t settings
);

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_CMD_A   = 6'b000010,
        PH_CMD_B   = 6'b000100,
        PH_REPSEL  = 6'b001000,
        PH_LITERAL = 6'b010000,
        PH_RAW     = 6'b100000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic                   first_bit_reg, first_bit_next;
    logic [COUNT_W-1:0]     lit_rem_reg, lit_rem_next;
    logic [PIXEL_CNT_W-1:0] issued_reg, issued_next;
    logic [PIXEL_CNT_W-1:0] total_reg, total_next;
    glyph_cfg_t             cfg_reg, cfg_next;

    logic                   accept, take_bit, take_start, sbit;
    logic [PIXEL_CNT_W-1:0] remaining;
    logic [COUNT_W-1:0]     req_n, count;
    logic                   last;
    op_t                    req_op;
    logic [5:0]             w_c, wl_c;
    logic [7:0]             h_c;

    assign in_ready   = (in_data.command == ITEM_START) ? back_quiet : !q_full;
    assign accept     = in_valid && in_ready;
    assign take_start = accept && (in_data.command == ITEM_START);
    assign take_bit   = accept && (in_data.command == ITEM_BIT);
    assign sbit       = in_data.stream_bit;
    assign start      = take_start;
    assign settings   = cfg_reg;

    // pixels still left in the glyph; the next command's count is cut to this
    assign remaining = total_reg - issued_reg;

    always_comb
    begin
        req_n  = COUNT_W'(1);
        req_op = OP_LIT;
        if (phase_reg == PH_CMD_B)
        begin
            req_n  = cfg_reg.word_length;
            req_op = OP_ZERO;
        end
        else if (phase_reg == PH_REPSEL)
        begin
            req_n  = sbit ? cfg_reg.width : cfg_reg.word_length;
            req_op = sbit ? OP_ROW : OP_WORD;
        end
    end

    assign last  = ({{(PIXEL_CNT_W-COUNT_W){1'b0}}, req_n} >= remaining);
    assign count = last ? remaining[COUNT_W-1:0] : req_n;

    // clamped glyph settings on a start
    always_comb
    begin
        w_c = in_data.glyph_width;
        if (w_c > 6'(WIDTH_CAP))
        begin
            w_c = 6'(WIDTH_CAP);
        end
        h_c = in_data.glyph_height;
        if (h_c > 8'(HEIGHT_CAP))
        begin
            h_c = 8'(HEIGHT_CAP);
        end
        wl_c = in_data.word_length;
        if (wl_c == '0)
        begin
            wl_c = 6'd1;
        end
        else if (wl_c > 6'(WORD_CAP))
        begin
            wl_c = 6'(WORD_CAP);
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        first_bit_next = first_bit_reg;
        lit_rem_next   = lit_rem_reg;
        issued_next    = issued_reg;
        total_next     = total_reg;
        cfg_next       = cfg_reg;
        push           = 1'b0;
        push_cmd.op      = req_op;
        push_cmd.count   = count;
        push_cmd.pix_bit = sbit;
        push_cmd.last    = last;

        if (take_start)
        begin
            cfg_next.origin_x    = in_data.origin_x;
            cfg_next.origin_y    = in_data.origin_y;
            cfg_next.width       = w_c;
            cfg_next.word_length = wl_c;
            cfg_next.color       = in_data.ink_color;
            total_next     = PIXEL_CNT_W'({7'b0, w_c} * {5'b0, h_c});
            issued_next    = '0;
            lit_rem_next   = '0;
            first_bit_next = 1'b0;
            phase_next     = (w_c == '0 || h_c == '0) ? PH_IDLE : PH_CMD_A;
        end
        else if (take_bit)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_CMD_A:
                begin
                    first_bit_next = sbit;
                    phase_next     = PH_CMD_B;
                end
                PH_CMD_B:
                begin
                    unique case ({first_bit_reg, sbit})
                        CODE_ESCAPE:
                        begin
                            phase_next = (issued_reg == '0) ? PH_RAW : PH_REPSEL;
                        end
                        CODE_ZERO_WORD:
                        begin
                            push       = 1'b1;
                            phase_next = last ? PH_IDLE : PH_CMD_A;
                        end
                        CODE_ROW_LIT:
                        begin
                            lit_rem_next = cfg_reg.width;
                            phase_next   = PH_LITERAL;
                        end
                        CODE_WORD_LIT:
                        begin
                            lit_rem_next = cfg_reg.word_length;
                            phase_next   = PH_LITERAL;
                        end
                    endcase
                end
                PH_REPSEL:
                begin
                    push       = 1'b1;
                    phase_next = last ? PH_IDLE : PH_CMD_A;
                end
                PH_LITERAL:
                begin
                    push         = 1'b1;
                    lit_rem_next = lit_rem_reg - COUNT_W'(1);
                    if (last)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (lit_rem_reg == COUNT_W'(1))
                    begin
                        phase_next = PH_CMD_A;
                    end
                end
                PH_RAW:
                begin
                    push       = 1'b1;
                    phase_next = last ? PH_IDLE : PH_RAW;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
            if (push)
            begin
                issued_next = issued_reg + PIXEL_CNT_W'(count);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            first_bit_reg <= 1'b0;
            lit_rem_reg   <= '0;
            issued_reg    <= '0;
            total_reg     <= '0;
            cfg_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            first_bit_reg <= first_bit_next;
            lit_rem_reg   <= lit_rem_next;
            issued_reg    <= issued_next;
            total_reg     <= total_next;
            cfg_reg       <= cfg_next;
        end
    end

endmodule

// ===== hw/rtl/gbd_back.sv =====
module gbd_back
    import gbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  glyph_cfg_t settings,
    input  clip_t      clip,
    input  logic       q_empty,
    input  cmd_t       q_head,
    output logic       q_pop,
    output logic       busy,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data
);

    logic                 busy_reg, busy_next;
    op_t                  op_reg, op_next;
    logic                 bit_reg, bit_next;
    logic                 last_reg, last_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [COUNT_W-1:0]   src_reg, src_next;
    logic [ROW_IDX_W-1:0] col_reg, col_next;
    logic [7:0]           row_reg, row_next;
    logic [ROW_IDX_W-1:0] base_reg, base_next;
    logic [ROW_IDX_W-1:0] wcnt_reg, wcnt_next;
    logic [ROW_CAP-1:0]   prev_reg, prev_next;
    logic [ROW_CAP-1:0]   cur_reg, cur_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_data_reg, out_data_next;

    logic                 emit, pix, wrap, inside_window;
    logic [ROW_CAP-1:0]   cur_upd;
    logic [COUNT_W-1:0]   col_inc;
    logic signed [15:0]   px, py;

    assign q_pop     = !busy_reg && !q_empty && !start;
    assign emit      = busy_reg && (!out_valid_reg || out_ready);
    assign busy      = busy_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // pixel source for the running command
    always_comb
    begin
        unique case (op_reg)
            OP_ZERO: pix = 1'b0;
            OP_LIT:  pix = bit_reg;
            OP_ROW:  pix = prev_reg[src_reg[ROW_IDX_W-1:0]];
            OP_WORD: pix = (src_reg < settings.width) ?
                           prev_reg[src_reg[ROW_IDX_W-1:0]] : 1'b0;
        endcase
    end

    assign px = settings.origin_x + 16'(col_reg);
    assign py = settings.origin_y + 16'(row_reg);
    assign inside_window = (px >= clip.left) && (px < clip.right) &&
                           (py >= clip.top) && (py < clip.bottom);

    assign col_inc = COUNT_W'(col_reg) + COUNT_W'(1);
    assign wrap    = (col_inc >= settings.width);

    always_comb
    begin
        cur_upd          = cur_reg;
        cur_upd[col_reg] = pix;
    end

    always_comb
    begin
        busy_next     = busy_reg;
        op_next       = op_reg;
        bit_next      = bit_reg;
        last_next     = last_reg;
        cnt_next      = cnt_reg;
        src_next      = src_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        base_next     = base_reg;
        wcnt_next     = wcnt_reg;
        prev_next     = prev_reg;
        cur_next      = cur_reg;
        out_data_next = out_data_reg;

        if (start)
        begin
            col_next  = '0;
            row_next  = '0;
            base_next = '0;
            wcnt_next = '0;
            prev_next = '0;
            cur_next  = '0;
        end
        else if (q_pop)
        begin
            busy_next = 1'b1;
            op_next   = q_head.op;
            bit_next  = q_head.pix_bit;
            last_next = q_head.last;
            cnt_next  = q_head.count;
            src_next  = (q_head.op == OP_WORD) ? COUNT_W'(base_reg) : '0;
        end
        else if (emit)
        begin
            cur_next = cur_upd;
            if (wrap)
            begin
                col_next  = '0;
                row_next  = row_reg + 8'd1;
                prev_next = cur_upd;
                base_next = '0;
                wcnt_next = '0;
            end
            else
            begin
                col_next = col_inc[ROW_IDX_W-1:0];
                if (COUNT_W'(wcnt_reg) + COUNT_W'(1) == settings.word_length)
                begin
                    base_next = col_inc[ROW_IDX_W-1:0];
                    wcnt_next = '0;
                end
                else
                begin
                    wcnt_next = wcnt_reg + ROW_IDX_W'(1);
                end
            end
            src_next = src_reg + COUNT_W'(1);
            cnt_next = cnt_reg - COUNT_W'(1);
            if (cnt_reg == COUNT_W'(1))
            begin
                busy_next = 1'b0;
            end
            out_data_next.pixel_x     = px;
            out_data_next.pixel_y     = py;
            out_data_next.write_pixel = pix && inside_window;
            out_data_next.pixel_color = settings.color;
            out_data_next.glyph_done  = last_reg && (cnt_reg == COUNT_W'(1));
        end
    end

    assign out_valid_next = emit || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            op_reg        <= OP_ZERO;
            cnt_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            base_reg      <= '0;
            wcnt_reg      <= '0;
            prev_reg      <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            base_reg      <= base_next;
            wcnt_reg      <= wcnt_next;
            prev_reg      <= prev_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg      <= bit_next;
        last_reg     <= last_next;
        src_reg      <= src_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== hw/rtl/glyph_bitmap_decompressor.sv =====
// glyph bitmap decompressor: a start transaction (command 0) loads origin, size, word length
// and ink color; each later transaction (command 1) carries one compressed bit, msb first.
// the parser takes one bit per cycle as long as its four-entry command queue has room, and
// turns bit pairs into commands (row or word repeat, zero word, literal pixels, raw mode).
// the pixel engine pops one command, then puts out one pixel per cycle, unless the output
// is stalled, through a registered output stage; a command makes 1 to 32 pixels.
// a start transaction is taken only once the queue and pixel engine have drained; the
// output register may still hold the last pixel. the user must write the clip registers
// through the plain cfg port while the block is idle; the block does not enforce this.
module glyph_bitmap_decompressor
    import gbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // clip window registers
    clip_t      clip_reg, clip_next;

    // parser to queue to pixel engine
    logic       push, start, q_full, q_empty, q_pop, back_busy, back_quiet;
    cmd_t       push_cmd, head_cmd;
    glyph_cfg_t settings;

    always_comb
    begin
        clip_next = clip_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CLIP_LEFT:   clip_next.left   = cfg_data;
                CFG_CLIP_RIGHT:  clip_next.right  = cfg_data;
                CFG_CLIP_TOP:    clip_next.top    = cfg_data;
                CFG_CLIP_BOTTOM: clip_next.bottom = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg.left   <= 16'sd0;
            clip_reg.right  <= 16'sd32767;
            clip_reg.top    <= 16'sd0;
            clip_reg.bottom <= 16'sd32767;
        end
        else
        begin
            clip_reg <= clip_next;
        end
    end

    // a new glyph may only start once the queue is empty and the pixel engine is idle
    assign back_quiet = q_empty && !back_busy;

    gbd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .q_full     (q_full),
        .back_quiet (back_quiet),
        .push       (push),
        .push_cmd   (push_cmd),
        .start      (start),
        .settings   (settings)
    );

    gbd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    gbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .settings  (settings),
        .clip      (clip_reg),
        .q_empty   (q_empty),
        .q_head    (head_cmd),
        .q_pop     (q_pop),
        .busy      (back_busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== hw/rtl/gbd_checker.sv =====
`include "glyph_bitmap_decompressor_macros.svh"

module gbd_checker
    import gbd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input in_item_t    in_data,
    input logic        out_valid,
    input logic        out_ready,
    input out_item_t   out_data,
    input logic        cfg_write,
    input logic [1:0]  cfg_index,
    input logic [15:0] cfg_data
);

    // mirror of the clip window as seen on the cfg port
    clip_t clip_reg, clip_next;
    logic  inside_window;
    logic  start_taken;

    always_comb
    begin
        clip_next = clip_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CLIP_LEFT:   clip_next.left   = cfg_data;
                CFG_CLIP_RIGHT:  clip_next.right  = cfg_data;
                CFG_CLIP_TOP:    clip_next.top    = cfg_data;
                CFG_CLIP_BOTTOM: clip_next.bottom = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg.left   <= 16'sd0;
            clip_reg.right  <= 16'sd32767;
            clip_reg.top    <= 16'sd0;
            clip_reg.bottom <= 16'sd32767;
        end
        else
        begin
            clip_reg <= clip_next;
        end
    end

    assign inside_window = (out_data.pixel_x >= clip_reg.left) &&
                           (out_data.pixel_x < clip_reg.right) &&
                           (out_data.pixel_y >= clip_reg.top) &&
                           (out_data.pixel_y < clip_reg.bottom);

    assign start_taken = in_valid && in_ready && (in_data.command == ITEM_START);

    `GBD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output transaction dropped or changed while stalled")

    `GBD_ASSERT_NOW(a_write_in_clip, out_valid && out_data.write_pixel, inside_window, "pixel written outside the clip window")

    `GBD_ASSERT_NEXT(a_start_drained, start_taken, !out_valid || $past(out_valid && !out_ready), "new pixel right after a start transaction")

endmodule

bind glyph_bitmap_decompressor gbd_checker u_gbd_checker (.*);
